>>> hw/rtl/ias_pkg.sv
`timescale 1ns / 1ps

package ias_pkg;

  // Field and state widths
  localparam int TEMP_W   = 12;
  localparam int LIGHT_W  = 16;
  localparam int SOIL_W   = 12;
  localparam int BASE_W   = 12;
  localparam int HOURS_W  = 16;
  localparam int IVAL_W   = 10;
  localparam int COUNT_W  = 24;
  localparam int TTOT_W   = 40;
  localparam int LTOT_W   = 48;
  localparam int QUO_W    = 16;
  localparam int DIFF_W   = 17;
  localparam int GAIN_W   = 16;
  localparam int AMOUNT_W = 16;
  localparam int CFG_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Item kinds
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_MINUTE = 2'd0;
  localparam mode_t MODE_HOUR   = 2'd1;
  localparam mode_t MODE_CHECK  = 2'd2;

  // Register indexes on the configuration port
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BASE_AMOUNT = 3'd0;
  localparam cfg_idx_t CFG_SOIL_TARGET = 3'd1;
  localparam cfg_idx_t CFG_TEMP_TARGET = 3'd2;
  localparam cfg_idx_t CFG_LIGHT_TARGET = 3'd3;
  localparam cfg_idx_t CFG_SOIL_GAIN = 3'd4;
  localparam cfg_idx_t CFG_TEMP_GAIN = 3'd5;
  localparam cfg_idx_t CFG_LIGHT_GAIN = 3'd6;
  localparam cfg_idx_t CFG_INTERVAL = 3'd7;

  // Control of the serial multiply-accumulate unit
  typedef struct packed {
    logic load;   // preset the accumulator
    logic start;  // begin one product
  } mac_ctl_t;

endpackage

>>> hw/rtl/ias_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUO_W bits, so the dividend bits above QUO_W preset the remainder.
module ias_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] bits;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, bits[QUO_W-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
  end

  // Shift the dividend in and the quotient bits out
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        rem   <= DEN_W'(num >> QUO_W);
        bits  <= num[QUO_W-1:0];
        den_q <= den;
        cnt   <= CNT_W'(QUO_W);
      end else if (cnt != '0) begin
        rem  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        bits <= {bits[QUO_W-2:0], take};
        cnt  <= cnt - CNT_W'(1);
      end
    end
  end

  assign quo = bits;

endmodule

>>> hw/rtl/ias_mac.sv
`timescale 1ns / 1ps

// Shift-and-add multiply-accumulate, one multiplier bit per cycle.
// The multiplier is two's complement: its top bit subtracts.
module ias_mac #(
  parameter int ACC_W = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ias_pkg::mac_ctl_t                  ctl,
  input  logic [ACC_W-1:0]                   init,
  input  logic signed [ias_pkg::DIFF_W-1:0]  mcand_in,
  input  logic [ias_pkg::GAIN_W-1:0]         mplier_in,
  output logic [ACC_W-1:0]                   acc,
  output logic                               done
);

  import ias_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [ACC_W-1:0]  mcand;
  logic [GAIN_W-1:0] mplier;
  logic [CNT_W-1:0]  cnt;
  logic              last;
  logic [ACC_W-1:0]  acc_next;

  // Add or, on the sign bit, subtract the shifted multiplicand
  always_comb begin
    last     = (cnt == CNT_W'(1));
    acc_next = acc;
    if (cnt != '0 && mplier[0]) begin
      acc_next = last ? (acc - mcand) : (acc + mcand);
    end
  end

  // Hold the accumulator and advance the operand shifters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (ctl.load) begin
        acc <= init;
      end else begin
        acc <= acc_next;
      end
      if (ctl.start) begin
        mcand  <= ACC_W'(mcand_in);
        mplier <= mplier_in;
        cnt    <= CNT_W'(GAIN_W);
      end else if (cnt != '0) begin
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
      end
    end
  end

  assign done = last;

endmodule

>>> hw/rtl/irrigation_amount_scheduler.sv
`timescale 1ns / 1ps

// Watering scheduler for one plant.
// Input stream s_*: one transfer per item. s_tuser holds the item kind
// (minute sample, hour tick, watering check) and the time-setup flag;
// s_tdata holds temperature, light and soil moisture samples.
// Output stream m_*: exactly one transfer per input item, in order.
// m_tuser is the watering request, m_tdata the amount, the countdown and
// the averages used by the last check that fired.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready. The user must
// write it only while no item is in flight; the block does not enforce it.
// Flow: minute and hour items and checks not yet due pass through ST_DONE to
// the output register. A check that fires runs the two bit-serial dividers
// that form the averages, then the shared serial multiplier for the three
// weighted deviations in turn, then ST_FIN to truncate and saturate and
// ST_DONE to present. One item is worked on at a time; the next is taken
// once the previous result sits in the output register, even while that
// register waits for m_tready.
// Reset restores the default registers, clears the sums, counts, the
// countdown and the held averages, and empties the output register.
module irrigation_amount_scheduler #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: temperature[11:0], light[27:12], soil_moisture[39:28]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: mode[1:0], in_time_setup[2]
  input  logic [2:0]  s_tuser,
  // m_tdata: water_amount[15:0], remaining_hours[31:16],
  //          temperature_average[43:32], light_average[59:44], zero[63:60]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  // m_tuser: water_now[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import ias_pkg::*;

  localparam int ACC_W = (GAIN_FRAC_BITS + 14 > 36) ? GAIN_FRAC_BITS + 14 : 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SOIL,
    ST_TEMP,
    ST_LIGHT,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [BASE_W-1:0]         base_amount;
  logic [SOIL_W-1:0]         soil_target;
  logic signed [TEMP_W-1:0]  temperature_target;
  logic [LIGHT_W-1:0]        light_target;
  logic signed [GAIN_W-1:0]  soil_gain;
  logic signed [GAIN_W-1:0]  temperature_gain;
  logic signed [GAIN_W-1:0]  light_gain;
  logic [IVAL_W-1:0]         interval_hours;

  // Scheduler state
  logic signed [HOURS_W-1:0] hours_left;
  logic signed [TTOT_W-1:0]  t_total;
  logic [COUNT_W-1:0]        t_count;
  logic [LTOT_W-1:0]         l_total;
  logic [COUNT_W-1:0]        l_count;
  logic signed [TEMP_W-1:0]  tavg_hold;
  logic [LIGHT_W-1:0]        lavg_hold;
  logic                      t_neg;
  logic signed [DIFF_W-1:0]  soil_diff;
  logic                      res_now;
  logic [AMOUNT_W-1:0]       res_amount;

  // Input fields
  mode_t                     in_mode;
  logic                      in_setup;
  logic signed [TEMP_W-1:0]  in_temp;
  logic [LIGHT_W-1:0]        in_light;
  logic [SOIL_W-1:0]         in_soil;

  logic                      accept;
  logic                      due;
  logic                      fire;
  logic [TTOT_W-1:0]         t_abs;
  logic [QUO_W-1:0]          t_quo;
  logic [QUO_W-1:0]          l_quo;
  logic [QUO_W-1:0]          t_signed_quo;
  logic                      t_done;
  logic                      l_done;

  mac_ctl_t                  mac_ctl;
  logic [ACC_W-1:0]          acc_init;
  logic signed [DIFF_W-1:0]  mac_diff;
  logic [GAIN_W-1:0]         mac_gain;
  logic [ACC_W-1:0]          acc;
  logic                      mac_done;
  logic                      acc_pos;
  logic                      acc_big;

  assign in_mode  = s_tuser[1:0];
  assign in_setup = s_tuser[2];
  assign in_temp  = s_tdata[11:0];
  assign in_light = s_tdata[27:12];
  assign in_soil  = s_tdata[39:28];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign due       = hours_left[HOURS_W-1] || (hours_left == '0);
  assign fire      = accept && (in_mode == MODE_CHECK) && due;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_amount        <= BASE_W'(100);
      soil_target        <= SOIL_W'(2000);
      temperature_target <= TEMP_W'(200);
      light_target       <= LIGHT_W'(1000);
      soil_gain          <= GAIN_W'(26);
      temperature_gain   <= GAIN_W'(26);
      light_gain         <= GAIN_W'(26);
      interval_hours     <= IVAL_W'(24);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_AMOUNT:  base_amount        <= cfg_data[BASE_W-1:0];
        CFG_SOIL_TARGET:  soil_target        <= cfg_data[SOIL_W-1:0];
        CFG_TEMP_TARGET:  temperature_target <= cfg_data[TEMP_W-1:0];
        CFG_LIGHT_TARGET: light_target       <= cfg_data[LIGHT_W-1:0];
        CFG_SOIL_GAIN:    soil_gain          <= cfg_data[GAIN_W-1:0];
        CFG_TEMP_GAIN:    temperature_gain   <= cfg_data[GAIN_W-1:0];
        CFG_LIGHT_GAIN:   light_gain         <= cfg_data[GAIN_W-1:0];
        CFG_INTERVAL:     interval_hours     <= cfg_data[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Averages: magnitude of the temperature sum, sign restored afterwards
  assign t_abs = t_total[TTOT_W-1] ? (TTOT_W'(0) - t_total) : t_total;

  ias_div #(
    .NUM_W(TTOT_W),
    .DEN_W(COUNT_W),
    .QUO_W(QUO_W)
  ) u_tdiv (
    .clk  (clk),
    .rst  (rst),
    .start(fire),
    .num  (t_abs),
    .den  (t_count),
    .quo  (t_quo),
    .done (t_done)
  );

  ias_div #(
    .NUM_W(LTOT_W),
    .DEN_W(COUNT_W),
    .QUO_W(QUO_W)
  ) u_ldiv (
    .clk  (clk),
    .rst  (rst),
    .start(fire),
    .num  (l_total),
    .den  (l_count),
    .quo  (l_quo),
    .done (l_done)
  );

  assign t_signed_quo = t_neg ? (QUO_W'(0) - t_quo) : t_quo;

  // Feed the three weighted deviations to the serial multiplier in turn
  assign acc_init = {{(ACC_W - BASE_W){1'b0}}, base_amount} << GAIN_FRAC_BITS;

  always_comb begin
    mac_ctl      = '0;
    mac_ctl.load = fire;
    mac_diff     = soil_diff;
    mac_gain     = soil_gain;
    case (state)
      ST_DIV: begin
        mac_ctl.start = t_done;
      end
      ST_SOIL: begin
        mac_ctl.start = mac_done;
        mac_diff      = DIFF_W'(tavg_hold) - DIFF_W'(temperature_target);
        mac_gain      = temperature_gain;
      end
      ST_TEMP: begin
        mac_ctl.start = mac_done;
        mac_diff      = DIFF_W'(lavg_hold) - DIFF_W'(light_target);
        mac_gain      = light_gain;
      end
      default: ;
    endcase
  end

  ias_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .init     (acc_init),
    .mcand_in (mac_diff),
    .mplier_in(mac_gain),
    .acc      (acc),
    .done     (mac_done)
  );

  assign acc_pos = !acc[ACC_W-1] && (acc != '0);
  assign acc_big = |acc[ACC_W-2:GAIN_FRAC_BITS+AMOUNT_W];

  // Sequencer, scheduler state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hours_left <= '0;
      t_total   <= '0;
      t_count   <= '0;
      l_total   <= '0;
      l_count   <= '0;
      tavg_hold <= '0;
      lavg_hold <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the output once taken, unless a new result replaces it
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_now    <= 1'b0;
            res_amount <= '0;
            state      <= ST_DONE;
            case (in_mode)
              MODE_MINUTE: begin
                if (!in_setup) begin
                  if (t_count != COUNT_MAX) begin
                    t_total <= t_total + TTOT_W'(in_temp);
                    t_count <= t_count + COUNT_W'(1);
                  end
                  if (l_count != COUNT_MAX) begin
                    l_total <= l_total + LTOT_W'(in_light);
                    l_count <= l_count + COUNT_W'(1);
                  end
                end
              end
              MODE_HOUR: begin
                if (hours_left != {1'b1, {(HOURS_W-1){1'b0}}}) begin
                  hours_left <= hours_left - HOURS_W'(1);
                end
              end
              MODE_CHECK: begin
                if (due) begin
                  soil_diff <= DIFF_W'(in_soil) - DIFF_W'(soil_target);
                  t_neg     <= t_total[TTOT_W-1];
                  state     <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (t_done) begin
            tavg_hold <= (t_count == '0) ? '0 : t_signed_quo[TEMP_W-1:0];
            lavg_hold <= (l_count == '0) ? '0 : l_quo[LIGHT_W-1:0];
            state     <= ST_SOIL;
          end
        end
        ST_SOIL: begin
          if (mac_done) begin
            state <= ST_TEMP;
          end
        end
        ST_TEMP: begin
          if (mac_done) begin
            state <= ST_LIGHT;
          end
        end
        ST_LIGHT: begin
          if (mac_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Truncate the fraction, saturate, and reload the countdown
          res_now    <= acc_pos;
          res_amount <= !acc_pos ? '0 :
                        acc_big ? {AMOUNT_W{1'b1}} : acc[GAIN_FRAC_BITS +: AMOUNT_W];
          hours_left <= HOURS_W'(interval_hours);
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_now;
            m_tdata  <= {4'd0, lavg_hold, tavg_hold, hours_left, res_amount};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Both dividers start together and take the same number of steps
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    t_done == l_done)
    else $error("average dividers out of step");

  // A firing check reloads the countdown from the interval register
  a_reload: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> hours_left == HOURS_W'($past(interval_hours)))
    else $error("countdown not reloaded after check");

  // No amount is shown without a watering request
  a_no_amount: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[15:0] == '0)
    else $error("amount without watering request");

endmodule
